// ===== sv/fmrt_pkg.sv =====
package fmrt_pkg;

  localparam logic [7:0] PROTO_BYTE_TCP  = 8'd6;
  localparam logic [7:0] PROTO_BYTE_UDP  = 8'd17;
  localparam logic [7:0] PROTO_BYTE_ICMP = 8'd1;
  localparam logic [7:0] PROTO_BYTE_IP   = 8'd0;

  typedef enum logic [1:0] {
    KIND_CLASSIFY = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DELETE   = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLS_TCP  = 2'd0,
    CLS_UDP  = 2'd1,
    CLS_ICMP = 2'd2,
    CLS_IP   = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RESOLVE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] rule_number;
    logic        rule_allow;
    logic [1:0]  rule_protocol;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic        source_port_any;
    logic [15:0] dest_port;
    logic        dest_port_any;
  } req_t;

  typedef struct packed {
    logic        accept;
    logic        rule_hit;
    logic [15:0] hit_number;
    logic [1:0]  status;
  } rsp_t;

  // one table entry; for a classify transaction the packet fields sit here too
  typedef struct packed {
    logic [15:0] number;
    logic        allow;
    cls_e        proto;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic        sport_any;
    logic [15:0] dport;
    logic        dport_any;
  } rule_t;

  typedef struct packed {
    kind_e kind;
    logic  cls_ok;
    cls_e  cls;
    rule_t rule;
  } cmd_t;

  typedef struct packed {
    logic eval;
    logic ins;
    logic rep;
    logic del;
  } ctl_t;

endpackage

// ===== sv/fmrt_cell.sv =====
module fmrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fmrt_pkg::ctl_t  ctl_i,
  input  fmrt_pkg::cmd_t  cmd_i,
  input  logic            in_use_i,
  input  fmrt_pkg::rule_t prev_rule_i,
  input  logic            prev_lt_i,
  input  fmrt_pkg::rule_t next_rule_i,
  input  logic            hit_i,
  output fmrt_pkg::rule_t rule_o,
  output logic            lt_o,
  output logic            eq_o,
  output logic            hit_o,
  output logic            first_o
);

  fmrt_pkg::rule_t rule_q, rule_d;
  logic match_q, match_d;
  logic lt_q, lt_d;
  logic eq_q, eq_d;
  logic proto_ok, sa_ok, da_ok, ports_ok, port_cls;

  always_comb begin
    proto_ok = (rule_q.proto == cmd_i.cls) || (rule_q.proto == fmrt_pkg::CLS_IP);
    sa_ok    = (rule_q.saddr == '0) || (cmd_i.rule.saddr == '0)
               || (rule_q.saddr == cmd_i.rule.saddr);
    da_ok    = (rule_q.daddr == '0) || (cmd_i.rule.daddr == '0)
               || (rule_q.daddr == cmd_i.rule.daddr);
    port_cls = (cmd_i.cls == fmrt_pkg::CLS_TCP) || (cmd_i.cls == fmrt_pkg::CLS_UDP);
    ports_ok = !port_cls
               || ((rule_q.sport_any || (rule_q.sport == cmd_i.rule.sport))
                   && (rule_q.dport_any || (rule_q.dport == cmd_i.rule.dport)));
    match_d  = in_use_i && cmd_i.cls_ok && proto_ok && sa_ok && da_ok && ports_ok;
    lt_d     = in_use_i && (rule_q.number < cmd_i.rule.number);
    eq_d     = in_use_i && (rule_q.number == cmd_i.rule.number);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else if (ctl_i.eval) begin
      match_q <= match_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  // insert: entries at and above the slot shift up; delete: shift down
  always_comb begin
    rule_d = rule_q;
    if (ctl_i.rep && eq_q) begin
      rule_d = cmd_i.rule;
    end else if (ctl_i.ins && !lt_q) begin
      rule_d = prev_lt_i ? cmd_i.rule : prev_rule_i;
    end else if (ctl_i.del && !lt_q) begin
      rule_d = next_rule_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rule_q <= rule_d;
  end

  assign rule_o  = rule_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;
  assign hit_o   = hit_i | match_q;
  assign first_o = match_q & ~hit_i;

endmodule

// ===== sv/first_match_packet_rule_table.sv =====
// First-match packet rule table.
// A transaction is taken on start_i while busy_o is low; req_i carries kind,
// rule fields for add/delete and packet header fields for classify.
// Rules live in a row of cells kept sorted by rule number; every cell
// compares its rule against the broadcast transaction in the same cycle,
// and add/delete shift the entries at and above the slot by one place together.
// Timing: accept edge -> compare cycle -> resolve/update cycle -> result.
// valid_o is registered from the resolve state and is high for exactly
// one cycle, in which the result is taken; rsp_o holds accept,
// rule_hit, hit_number and status.
// busy_o is high in the compare and resolve states; the next
// transaction can be taken at the edge that ends the result cycle, so a
// new transaction is not taken before the last one is through the
// registered compare stage, the resolve stage and the result register.
// The receiver cannot stall: the result must be taken in its cycle.
// Reset empties the table (rule count zero) and returns to idle; the
// entries themselves are not cleared and are ignored above the count.
module first_match_packet_rule_table #(
  parameter int MAX_RULES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  fmrt_pkg::req_t req_i,
  output logic           busy_o,
  output logic           valid_o,
  output fmrt_pkg::rsp_t rsp_o
);

  localparam int CntW = $clog2(MAX_RULES + 1);

  fmrt_pkg::state_e state_q, state_d;
  fmrt_pkg::cmd_t   cmd_q, cmd_d;
  fmrt_pkg::ctl_t   ctl;
  fmrt_pkg::rsp_t   rsp_q, rsp_d;
  logic             valid_q;
  logic [CntW-1:0]  count_q, count_d;

  fmrt_pkg::rule_t  rules [MAX_RULES];
  logic [MAX_RULES-1:0] lt, eq, first, in_use;
  logic [MAX_RULES:0]   hit_c;

  logic        accepted, full, any_eq, any_hit, sel_allow;
  logic [15:0] sel_number;

  assign accepted = start_i && (state_q == fmrt_pkg::S_IDLE);
  assign full     = (count_q == CntW'(MAX_RULES));
  assign any_eq   = |eq;
  assign any_hit  = hit_c[MAX_RULES];

  always_comb begin
    cmd_d                = cmd_q;
    cmd_d.kind           = fmrt_pkg::kind_e'(req_i.kind);
    cmd_d.rule.number    = req_i.rule_number;
    cmd_d.rule.allow     = req_i.rule_allow;
    cmd_d.rule.proto     = fmrt_pkg::cls_e'(req_i.rule_protocol);
    cmd_d.rule.saddr     = req_i.source_address;
    cmd_d.rule.daddr     = req_i.dest_address;
    cmd_d.rule.sport     = req_i.source_port;
    cmd_d.rule.sport_any = req_i.source_port_any;
    cmd_d.rule.dport     = req_i.dest_port;
    cmd_d.rule.dport_any = req_i.dest_port_any;
    cmd_d.cls_ok         = (req_i.kind == fmrt_pkg::KIND_CLASSIFY);
    cmd_d.cls            = fmrt_pkg::CLS_IP;
    priority if (req_i.ip_protocol == fmrt_pkg::PROTO_BYTE_TCP) begin
      cmd_d.cls = fmrt_pkg::CLS_TCP;
    end else if (req_i.ip_protocol == fmrt_pkg::PROTO_BYTE_UDP) begin
      cmd_d.cls = fmrt_pkg::CLS_UDP;
    end else if (req_i.ip_protocol == fmrt_pkg::PROTO_BYTE_ICMP) begin
      cmd_d.cls = fmrt_pkg::CLS_ICMP;
    end else if (req_i.ip_protocol == fmrt_pkg::PROTO_BYTE_IP) begin
      cmd_d.cls = fmrt_pkg::CLS_IP;
    end else begin
      cmd_d.cls_ok = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accepted) begin
      cmd_q <= cmd_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmrt_pkg::S_IDLE:    if (start_i) state_d = fmrt_pkg::S_EVAL;
      fmrt_pkg::S_EVAL:    state_d = fmrt_pkg::S_RESOLVE;
      fmrt_pkg::S_RESOLVE: state_d = fmrt_pkg::S_IDLE;
      default:             state_d = fmrt_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl      = '0;
    ctl.eval = (state_q == fmrt_pkg::S_EVAL);
    if (state_q == fmrt_pkg::S_RESOLVE) begin
      ctl.rep = (cmd_q.kind == fmrt_pkg::KIND_ADD) && any_eq;
      ctl.ins = (cmd_q.kind == fmrt_pkg::KIND_ADD) && !any_eq && !full;
      ctl.del = (cmd_q.kind == fmrt_pkg::KIND_DELETE) && any_eq;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmrt_pkg::S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= (state_q == fmrt_pkg::S_RESOLVE);
    end
  end

  assign hit_c[0] = 1'b0;

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    fmrt_pkg::rule_t prev_rule, next_rule;
    logic            prev_lt;

    assign in_use[i] = (count_q > CntW'(i));
    if (i == 0) begin : g_head
      assign prev_rule = rules[0];
      assign prev_lt   = 1'b1;
    end else begin : g_body
      assign prev_rule = rules[i-1];
      assign prev_lt   = lt[i-1];
    end
    if (i == MAX_RULES - 1) begin : g_tail
      assign next_rule = rules[i];
    end else begin : g_next
      assign next_rule = rules[i+1];
    end

    fmrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .cmd_i       (cmd_q),
      .in_use_i    (in_use[i]),
      .prev_rule_i (prev_rule),
      .prev_lt_i   (prev_lt),
      .next_rule_i (next_rule),
      .hit_i       (hit_c[i]),
      .rule_o      (rules[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i]),
      .hit_o       (hit_c[i+1]),
      .first_o     (first[i])
    );
  end

  // at most one cell flags itself as the first match
  always_comb begin
    sel_number = '0;
    sel_allow  = 1'b0;
    for (int i = 0; i < MAX_RULES; i++) begin
      sel_number = sel_number | ({16{first[i]}} & rules[i].number);
      sel_allow  = sel_allow | (first[i] & rules[i].allow);
    end
  end

  always_comb begin
    rsp_d = '0;
    unique case (cmd_q.kind)
      fmrt_pkg::KIND_CLASSIFY: begin
        rsp_d.rule_hit   = any_hit;
        rsp_d.hit_number = sel_number;
        rsp_d.accept     = any_hit ? sel_allow : 1'b1;
      end
      fmrt_pkg::KIND_ADD: begin
        if (!any_eq && full) rsp_d.status = fmrt_pkg::ST_FULL;
      end
      fmrt_pkg::KIND_DELETE: begin
        if (!any_eq) rsp_d.status = fmrt_pkg::ST_MISSING;
      end
      default: rsp_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fmrt_pkg::S_RESOLVE) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o  = (state_q != fmrt_pkg::S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RULES))
    else $error("rule count above table size");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q == fmrt_pkg::S_RESOLVE))
    else $error("rule count changed outside resolve");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted |=> ##2 valid_o)
    else $error("result not delivered three cycles after transaction");

  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.rule_hit |-> rsp_o.status == fmrt_pkg::ST_OK)
    else $error("rule hit with error status");

endmodule
